### src/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, sampled on clk_i, off while rst_ni is low.
`define ETL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define ETL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/etl_pkg.sv
`default_nettype none

package etl_pkg;

  localparam int unsigned MaxDigits = 18;
  localparam int unsigned MantW     = 60;
  localparam int unsigned FracW     = 5;
  localparam int unsigned KindW     = 5;
  localparam int unsigned NumSlots  = 3;

  // Token kinds
  localparam logic [KindW-1:0] TkPlus    = 5'd0;
  localparam logic [KindW-1:0] TkMinus   = 5'd1;
  localparam logic [KindW-1:0] TkStar    = 5'd2;
  localparam logic [KindW-1:0] TkSlash   = 5'd3;
  localparam logic [KindW-1:0] TkLParen  = 5'd4;
  localparam logic [KindW-1:0] TkRParen  = 5'd5;
  localparam logic [KindW-1:0] TkBang    = 5'd6;
  localparam logic [KindW-1:0] TkNotEq   = 5'd7;
  localparam logic [KindW-1:0] TkAssign  = 5'd8;
  localparam logic [KindW-1:0] TkEqEq    = 5'd9;
  localparam logic [KindW-1:0] TkAmp     = 5'd10;
  localparam logic [KindW-1:0] TkAndAnd  = 5'd11;
  localparam logic [KindW-1:0] TkBar     = 5'd12;
  localparam logic [KindW-1:0] TkOrOr    = 5'd13;
  localparam logic [KindW-1:0] TkLt      = 5'd14;
  localparam logic [KindW-1:0] TkLe      = 5'd15;
  localparam logic [KindW-1:0] TkShl     = 5'd16;
  localparam logic [KindW-1:0] TkGt      = 5'd17;
  localparam logic [KindW-1:0] TkGe      = 5'd18;
  localparam logic [KindW-1:0] TkShr     = 5'd19;
  localparam logic [KindW-1:0] TkCaret   = 5'd20;
  localparam logic [KindW-1:0] TkTilde   = 5'd21;
  localparam logic [KindW-1:0] TkPercent = 5'd22;
  localparam logic [KindW-1:0] TkNewline = 5'd23;
  localparam logic [KindW-1:0] TkNumber  = 5'd24;
  localparam logic [KindW-1:0] TkEnd     = 5'd25;

  typedef enum logic [2:0] {
    PendNone  = 3'd0,
    PendBang  = 3'd1,
    PendEq    = 3'd2,
    PendAmp   = 3'd3,
    PendBar   = 3'd4,
    PendLt    = 3'd5,
    PendGt    = 3'd6,
    PendMinus = 3'd7
  } pend_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0] token_kind;
    logic [MantW-1:0] mantissa;
    logic [FracW-1:0] fraction_digits;
    logic             overflowed;
    logic             last_of_run;
  } tok_t;

  typedef struct packed {
    pend_e            pending;
    logic             in_number;
    logic [MantW-1:0] acc;
    logic [FracW-1:0] frac;
    logic [1:0]       dots;
    logic             ovf;
    logic             in_comment;
  } lex_state_t;

  // Largest mantissa kept: 10^MaxDigits - 1, evaluated at elaboration.
  function automatic logic [MantW-1:0] mant_limit();
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < MaxDigits; i++) begin
      v = v * 64'd10;
    end
    return MantW'(v - 64'd1);
  endfunction

  localparam logic [MantW-1:0] MantLimit = mant_limit();

endpackage

`default_nettype wire

### src/etl_step.sv
`default_nettype none

module etl_step import etl_pkg::*; (
  input  in_item_t             item_i,
  input  lex_state_t           state_i,
  output lex_state_t           state_o,
  output tok_t [NumSlots-1:0]  res_o,
  output logic [1:0]           count_o
);

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChLt      = 8'h3C;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChCaret   = 8'h5E;
  localparam logic [7:0] ChBar     = 8'h7C;
  localparam logic [7:0] ChTilde   = 8'h7E;

  localparam int unsigned NumCand = 6;

  function automatic logic [KindW-1:0] single_kind(input pend_e p);
    case (p)
      PendBang: return TkBang;
      PendEq:   return TkAssign;
      PendAmp:  return TkAmp;
      PendBar:  return TkBar;
      PendLt:   return TkLt;
      PendGt:   return TkGt;
      default:  return TkMinus;
    endcase
  endfunction

  function automatic tok_t op_tok(input logic [KindW-1:0] k);
    tok_t t;
    t = '0;
    t.token_kind = k;
    return t;
  endfunction

  logic [7:0]  c;
  logic        c_nz;
  logic        is_digit;
  logic        is_dot;
  logic [3:0]  digit;
  logic [63:0] prod;

  assign c        = item_i.char_code;
  assign c_nz     = (c != ChNul);
  assign is_digit = (c >= ChZero) && (c <= ChNine);
  assign is_dot   = (c == ChDot);
  assign digit    = 4'(c - ChZero);
  assign prod     = {4'b0, state_i.acc} * 64'd10 + {60'b0, digit};

  lex_state_t           nxt;
  tok_t [NumCand-1:0]   cand;
  logic [NumCand-1:0]   cv;
  logic                 go;
  logic                 pair_hit;
  logic [KindW-1:0]     pair_kind;
  tok_t [NumSlots-1:0]  res;
  logic [1:0]           n;

  always_comb begin
    nxt       = state_i;
    cand      = '0;
    cv        = '0;
    go        = 1'b0;
    pair_hit  = 1'b0;
    pair_kind = TkPlus;

    // Character processing
    if (c_nz) begin
      if (state_i.in_comment) begin
        if (c == ChNewline) begin
          nxt.in_comment = 1'b0;
        end
      end else begin
        go = 1'b1;
        if (state_i.pending != PendNone) begin
          nxt.pending = PendNone;
          case (state_i.pending)
            PendBang: begin
              pair_hit = (c == ChEq); pair_kind = TkNotEq;
            end
            PendEq: begin
              pair_hit = (c == ChEq); pair_kind = TkEqEq;
            end
            PendAmp: begin
              pair_hit = (c == ChAmp); pair_kind = TkAndAnd;
            end
            PendBar: begin
              pair_hit = (c == ChBar); pair_kind = TkOrOr;
            end
            PendLt: begin
              pair_hit  = (c == ChEq) || (c == ChLt);
              pair_kind = (c == ChEq) ? TkLe : TkShl;
            end
            PendGt: begin
              pair_hit  = (c == ChEq) || (c == ChGt);
              pair_kind = (c == ChEq) ? TkGe : TkShr;
            end
            default: begin
              pair_hit = 1'b0;
            end
          endcase
          if (pair_hit) begin
            cv[0]   = 1'b1;
            cand[0] = op_tok(pair_kind);
            go      = 1'b0;
          end else if (state_i.pending == PendMinus && c == ChBar) begin
            nxt.in_comment = 1'b1;
            go             = 1'b0;
          end else begin
            cv[0]   = 1'b1;
            cand[0] = op_tok(single_kind(state_i.pending));
          end
        end

        if (go) begin
          if (is_dot) begin
            nxt.in_number = 1'b1;
            if (state_i.dots != 2'd2) begin
              nxt.dots = state_i.dots + 2'd1;
            end
          end else if (is_digit) begin
            nxt.in_number = 1'b1;
            if (state_i.dots == 2'd2 || state_i.ovf) begin
              // digits after a second dot or after overflow are ignored
            end else if (state_i.dots == 2'd1 && state_i.frac >= FracW'(MaxDigits)) begin
              nxt.ovf = 1'b1;
            end else if (prod > {4'b0, MantLimit}) begin
              nxt.acc = MantLimit;
              nxt.ovf = 1'b1;
            end else begin
              nxt.acc = prod[MantW-1:0];
              if (state_i.dots == 2'd1) begin
                nxt.frac = state_i.frac + 5'd1;
              end
            end
          end else begin
            if (state_i.in_number) begin
              cv[1]                   = 1'b1;
              cand[1].token_kind      = TkNumber;
              cand[1].mantissa        = state_i.acc;
              cand[1].fraction_digits = state_i.frac;
              cand[1].overflowed      = state_i.ovf;
            end
            nxt.in_number = 1'b0;
            nxt.acc       = '0;
            nxt.frac      = '0;
            nxt.dots      = '0;
            nxt.ovf       = 1'b0;
            case (c)
              ChBang:    nxt.pending = PendBang;
              ChEq:      nxt.pending = PendEq;
              ChAmp:     nxt.pending = PendAmp;
              ChBar:     nxt.pending = PendBar;
              ChLt:      nxt.pending = PendLt;
              ChGt:      nxt.pending = PendGt;
              ChMinus:   nxt.pending = PendMinus;
              ChPlus:    begin cv[2] = 1'b1; cand[2] = op_tok(TkPlus);    end
              ChStar:    begin cv[2] = 1'b1; cand[2] = op_tok(TkStar);    end
              ChSlash:   begin cv[2] = 1'b1; cand[2] = op_tok(TkSlash);   end
              ChLParen:  begin cv[2] = 1'b1; cand[2] = op_tok(TkLParen);  end
              ChRParen:  begin cv[2] = 1'b1; cand[2] = op_tok(TkRParen);  end
              ChCaret:   begin cv[2] = 1'b1; cand[2] = op_tok(TkCaret);   end
              ChTilde:   begin cv[2] = 1'b1; cand[2] = op_tok(TkTilde);   end
              ChPercent: begin cv[2] = 1'b1; cand[2] = op_tok(TkPercent); end
              ChNewline: begin cv[2] = 1'b1; cand[2] = op_tok(TkNewline); end
              default:   cv[2] = 1'b0;
            endcase
          end
        end
      end
    end

    // End of text: flush pending operator and number, then end token
    if (!c_nz || item_i.final_char) begin
      if (nxt.pending != PendNone) begin
        cv[3]   = 1'b1;
        cand[3] = op_tok(single_kind(nxt.pending));
      end
      if (nxt.in_number) begin
        cv[4]                   = 1'b1;
        cand[4].token_kind      = TkNumber;
        cand[4].mantissa        = nxt.acc;
        cand[4].fraction_digits = nxt.frac;
        cand[4].overflowed      = nxt.ovf;
      end
      cv[5]   = 1'b1;
      cand[5] = op_tok(TkEnd);
      nxt     = '0;
    end
  end

  // Pack the produced tokens in order; at most three per character.
  always_comb begin
    res = '0;
    n   = 2'd0;
    for (int i = 0; i < NumCand; i++) begin
      if (cv[i] && n != 2'd3) begin
        res[n] = cand[i];
        n      = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last_of_run = 1'b1;
    end
  end

  assign state_o = nxt;
  assign res_o   = res;
  assign count_o = n;

endmodule

`default_nettype wire

### src/expression_token_lexer.sv
// Expression token lexer: one text character in, zero to three tokens out.
// Input channel: in_item_i (char_code, final_char) with in_valid_i/in_stall_o.
//   A zero char_code or a set final_char ends the text: pending operator and
//   number are flushed, an end token follows, and the lexer starts a new text.
// Output channel: out_item_o (token_kind, mantissa, fraction_digits,
//   overflowed, last_of_run) with out_valid_o/out_stall_i. last_of_run marks
//   the final token caused by one character.
// Output: tokens of a character appear on the output in the cycle after it is
//   accepted; its second and third token follow as earlier tokens leave.
// Throughput: one character per cycle while each character makes at most one
//   token and out_stall_i is low. The three-entry token buffer drains one token
//   per cycle unless stalled, and holds the input until its last token leaves.
// Stall: when out_stall_i is high the token buffer holds and in_stall_o rises
//   as soon as the buffer cannot be refilled; a character is taken in the same
//   cycle the last buffered token leaves.
// Reset: asynchronous, active low. Clears the lexer state (no pending
//   operator, no number, no comment) and empties the token buffer.
`default_nettype none

module expression_token_lexer import etl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tok_t     out_item_o
);

  lex_state_t           state_q, state_d;
  tok_t [NumSlots-1:0]  slot_q, slot_d;
  logic [1:0]           cnt_q, cnt_d;
  tok_t [NumSlots-1:0]  step_res;
  logic [1:0]           step_cnt;
  logic                 in_take;
  logic                 out_take;

  // Per-character lexing: state plus character -> tokens and next state
  etl_step u_step (
    .item_i  (in_item_i),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (step_res),
    .count_o (step_cnt)
  );

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = slot_q[0];
  assign out_take    = out_valid_o && !out_stall_i;

  // Accept when the buffer is empty or its last token leaves this cycle
  assign in_stall_o  = !((cnt_q == 2'd0) || (cnt_q == 2'd1 && out_take));
  assign in_take     = in_valid_i && !in_stall_o;

  always_comb begin
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (in_take) begin
      cnt_d  = step_cnt;
      slot_d = step_res;
    end else if (out_take) begin
      cnt_d     = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (in_take) begin
        state_q <= state_d;
      end
    end
  end

  // token buffer payload
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

### src/etl_checker.sv
`default_nettype none
`include "assert_macros.svh"

module etl_checker import etl_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input in_item_t in_item_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input tok_t     out_item_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_item_i);

  `ETL_ASSERT_NEXT(a_out_valid_hold, out_valid_o && out_stall_i, out_valid_o, "token dropped while stalled")
  `ETL_ASSERT_NEXT(a_out_item_hold, out_valid_o && out_stall_i, $stable(out_item_o), "stalled token changed")
  `ETL_ASSERT(a_stall_needs_tokens, (in_stall_o |-> out_valid_o), "input stalled with empty buffer")
  `ETL_ASSERT_NEXT(a_run_continues, out_valid_o && !out_stall_i && !out_item_o.last_of_run, out_valid_o, "token run cut short")
  `ETL_ASSERT(a_op_payload_zero, (out_valid_o && out_item_o.token_kind != TkNumber |-> out_item_o.mantissa == '0 && out_item_o.fraction_digits == '0 && !out_item_o.overflowed), "operator token has number payload")

endmodule

bind expression_token_lexer etl_checker u_etl_checker (.*);

`default_nettype wire
